/* design/kcl_pkg.sv */
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad code lock
// Key and code widths, status codes, register map and configuration struct.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

   localparam int CODE_KEYS = 5;
   localparam int KEY_W     = 8;
   localparam int CODE_W    = KEY_W * CODE_KEYS;
   localparam int KEY_POS_W = (CODE_KEYS > 1) ? $clog2(CODE_KEYS) : 1;
   localparam int FAIL_W    = 3;
   localparam int STATUS_W  = 4;

   localparam int PASSKEY_W = 40;
   localparam int LIMIT_W   = 3;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

   localparam logic [PASSKEY_W-1:0] PASSKEY_RESET = 40'h41_4243_4344;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 3'd4;
   localparam logic [CODE_W-1:0]    STORED_RESET  = {CODE_KEYS{8'h30}};

   typedef enum logic [0:0] {
      REG_PASSKEY = 1'b0,
      REG_LIMIT   = 1'b1
   } reg_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_KEY_TAKEN   = 4'd0,
      ST_GRANTED     = 4'd1,
      ST_CHANGE      = 4'd2,
      ST_OLD_OK      = 4'd3,
      ST_OLD_WRONG   = 4'd4,
      ST_NEW_TAKEN   = 4'd5,
      ST_CHANGED     = 4'd6,
      ST_MISMATCH    = 4'd7,
      ST_WRONG       = 4'd8,
      ST_LOCKOUT     = 4'd9,
      ST_IGNORED     = 4'd10
   } status_type;

   typedef struct packed {
      logic [PASSKEY_W-1:0] master_passkey;
      logic [LIMIT_W-1:0]   max_failures;
   } cfg_type;

endpackage

`default_nettype wire

/* design/kcl_if.sv */
// ----------------------------------------------------------------------------
// kcl_req_if / kcl_rsp_if: key and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcl_req_if;
   import kcl_pkg::*;

   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key_code;

   modport source (output valid, output key_code, input ready);
   modport sink   (input valid, input key_code, output ready);
endinterface

interface kcl_rsp_if;
   import kcl_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                door_open;
   logic                code_changed;
   logic [FAIL_W-1:0]   failures;

   modport source (output valid, output status, output door_open,
                   output code_changed, output failures, input ready);
   modport sink   (input valid, input status, input door_open,
                   input code_changed, input failures, output ready);
endinterface

`default_nettype wire

/* design/kcl_csr.sv */
// ----------------------------------------------------------------------------
// kcl_csr: configuration registers
// APB-style access to the master passkey and the failure limit.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_csr
   import kcl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1]);
   assign write      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (index)
            REG_PASSKEY: cfg_in.master_passkey = csr_pwdata[PASSKEY_W-1:0];
            REG_LIMIT:   cfg_in.max_failures   = csr_pwdata[LIMIT_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_PASSKEY: csr_prdata = CSR_DATA_W'(cfg_ff.master_passkey);
         REG_LIMIT:   csr_prdata = CSR_DATA_W'(cfg_ff.max_failures);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.master_passkey <= PASSKEY_RESET;
         cfg_ff.max_failures   <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* design/keypad_code_lock.sv */
// ----------------------------------------------------------------------------
// keypad_code_lock: keypad combination lock
// Gathers key words into codes, checks them against the stored code and the
// master passkey, runs the code change flow and locks after too many failures.
// Result words are registered and show in the cycle after their key word.
// One key word per cycle; the result register stalls keys until it drains.
// Reset: synchronous; clears phase, key count and failures, loads the default
// code and the default passkey and limit.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_code_lock
   import kcl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   kcl_req_if.sink                    req,
   kcl_rsp_if.source                  rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [2:0] {
      PH_ENTRY,
      PH_OLD,
      PH_NEW,
      PH_CONFIRM,
      PH_LOCKED
   } phase_type;

   cfg_type cfg;

   phase_type            phase_ff,  phase_in;
   logic [KEY_POS_W-1:0] pos_ff,    pos_in;
   logic [FAIL_W-1:0]    fail_ff,   fail_in;
   logic [CODE_W-1:0]    stored_ff, stored_in;
   logic [CODE_W-1:0]    entry_ff,  entry_in;
   logic [CODE_W-1:0]    new_ff,    new_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff,    status_in;
   logic                 door_ff,      door_in;
   logic                 changed_ff,   changed_in;
   logic [FAIL_W-1:0]    failures_ff,  failures_in;

   logic                 accept;
   logic                 last_key;
   logic [CODE_W-1:0]    code;
   logic [FAIL_W-1:0]    fail_inc;
   logic                 lock_hit;

   kcl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req.ready        = !rsp_valid_ff || rsp.ready;
   assign accept           = req.valid && req.ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.door_open    = door_ff;
   assign rsp.code_changed = changed_ff;
   assign rsp.failures     = failures_ff;

   assign code     = (entry_ff << KEY_W) | CODE_W'(req.key_code);
   assign last_key = (pos_ff == KEY_POS_W'(CODE_KEYS - 1));
   assign fail_inc = (fail_ff == FAIL_MAX) ? fail_ff : fail_ff + FAIL_W'(1);
   assign lock_hit = (fail_inc >= cfg.max_failures);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      fail_in   = fail_ff;
      stored_in = stored_ff;
      entry_in  = entry_ff;
      new_in    = new_ff;
      status_in = ST_KEY_TAKEN;
      door_in   = 1'b0;
      changed_in = 1'b0;

      if (phase_ff == PH_LOCKED) begin
         status_in = ST_IGNORED;
      end else begin
         entry_in = code;
         pos_in   = pos_ff + KEY_POS_W'(1);
         if (last_key) begin
            pos_in = '0;
            unique case (phase_ff)
               PH_ENTRY: begin
                  if (code == stored_ff) begin
                     status_in = ST_GRANTED;
                     door_in   = 1'b1;
                     fail_in   = '0;
                  end else if (code == CODE_W'(cfg.master_passkey)) begin
                     status_in = ST_CHANGE;
                     phase_in  = PH_OLD;
                  end else begin
                     fail_in   = fail_inc;
                     status_in = lock_hit ? ST_LOCKOUT : ST_WRONG;
                     phase_in  = lock_hit ? PH_LOCKED : PH_ENTRY;
                  end
               end
               PH_OLD: begin
                  if (code == stored_ff) begin
                     status_in = ST_OLD_OK;
                     fail_in   = '0;
                     phase_in  = PH_NEW;
                  end else begin
                     fail_in   = fail_inc;
                     status_in = lock_hit ? ST_LOCKOUT : ST_OLD_WRONG;
                     phase_in  = lock_hit ? PH_LOCKED : PH_ENTRY;
                  end
               end
               PH_NEW: begin
                  new_in    = code;
                  status_in = ST_NEW_TAKEN;
                  phase_in  = PH_CONFIRM;
               end
               PH_CONFIRM: begin
                  if (code == new_ff) begin
                     stored_in  = code;
                     status_in  = ST_CHANGED;
                     changed_in = 1'b1;
                  end else begin
                     status_in = ST_MISMATCH;
                  end
                  phase_in = PH_ENTRY;
               end
               default: phase_in = PH_LOCKED;
            endcase
         end
      end
      failures_in = fail_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ENTRY;
         pos_ff       <= '0;
         fail_ff      <= '0;
         stored_ff    <= STORED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            fail_ff   <= fail_in;
            stored_ff <= stored_in;
         end
      end
      if (accept) begin
         entry_ff    <= entry_in;
         new_ff      <= new_in;
         status_ff   <= status_in;
         door_ff     <= door_in;
         changed_ff  <= changed_in;
         failures_ff <= failures_in;
      end
   end

endmodule

`default_nettype wire
